// File: rtl/nps_pkg.sv
// Shared types and constants for the nearest point snap block.
package nps_pkg;

    localparam int COORD_BITS = 16;
    localparam int INDEX_BITS = 16;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int SUM_BITS   = SQ_BITS + 1;
    localparam int DIST_BITS  = 34;
    localparam int LIMIT_BITS = 33;
    localparam int START_VALUE = 10000;
    localparam int BEST_BITS  = $clog2(START_VALUE + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [INDEX_BITS-1:0]        index_t;
    typedef logic [SQ_BITS-1:0]           square_t;
    typedef logic [SUM_BITS-1:0]          dist_sum_t;
    typedef logic [DIST_BITS-1:0]         dist_t;
    typedef logic [LIMIT_BITS-1:0]        limit_t;
    typedef logic [BEST_BITS-1:0]         best_dist_t;

    localparam best_dist_t START_DISTANCE = best_dist_t'(START_VALUE);
    localparam limit_t     LIMIT_RESET    = limit_t'(START_VALUE);

    typedef struct packed {
        coord_t query_x;
        coord_t query_y;
        coord_t point_x;
        coord_t point_y;
        index_t element_index;
        index_t point_index;
        logic   has_point;
        logic   last_item;
    } snap_in_t;

    typedef struct packed {
        coord_t snap_x;
        coord_t snap_y;
        logic   found;
        index_t found_element;
        index_t found_point;
    } snap_out_t;

    // Payload of the squared-difference stage.
    typedef struct packed {
        square_t sq_x;
        square_t sq_y;
        coord_t  query_x;
        coord_t  query_y;
        coord_t  point_x;
        coord_t  point_y;
        index_t  element_index;
        index_t  point_index;
        logic    has_point;
        logic    last_item;
    } dist_stage_t;

endpackage

// File: rtl/nps_dist.sv
// Input register and squared coordinate difference stage.
module nps_dist (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  nps_pkg::snap_in_t    item,
    input  logic                 advance,
    output logic                 stage_valid,
    output nps_pkg::dist_stage_t stage
);
    import nps_pkg::*;

    logic        s0_valid_reg;
    snap_in_t    s0_reg;
    logic        s1_valid_reg;
    dist_stage_t s1_reg;

    logic        load_s0;
    logic [COORD_BITS:0] diff_x;
    logic [COORD_BITS:0] diff_y;
    logic [COORD_BITS:0] neg_x;
    logic [COORD_BITS:0] neg_y;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    dist_stage_t s1_next;

    // Stage 0 may load when empty or when its item moves on.
    assign load_s0    = !s0_valid_reg || advance;
    assign item_ready = load_s0;

    always_comb
    begin
        diff_x = {s0_reg.point_x[COORD_BITS-1], s0_reg.point_x}
               - {s0_reg.query_x[COORD_BITS-1], s0_reg.query_x};
        diff_y = {s0_reg.point_y[COORD_BITS-1], s0_reg.point_y}
               - {s0_reg.query_y[COORD_BITS-1], s0_reg.query_y};
        neg_x  = ~diff_x + 1'b1;
        neg_y  = ~diff_y + 1'b1;
        // The magnitude never exceeds 2^COORD_BITS - 1.
        mag_x  = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
        mag_y  = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];

        s1_next               = '0;
        s1_next.sq_x          = mag_x * mag_x;
        s1_next.sq_y          = mag_y * mag_y;
        s1_next.query_x       = s0_reg.query_x;
        s1_next.query_y       = s0_reg.query_y;
        s1_next.point_x       = s0_reg.point_x;
        s1_next.point_y       = s0_reg.point_y;
        s1_next.element_index = s0_reg.element_index;
        s1_next.point_index   = s0_reg.point_index;
        s1_next.has_point     = s0_reg.has_point;
        s1_next.last_item     = s0_reg.last_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s0)
            begin
                s0_valid_reg <= item_valid;
            end
            if (advance)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s0 && item_valid)
        begin
            s0_reg <= item;
        end
        if (advance && s0_valid_reg)
        begin
            s1_reg <= s1_next;
        end
    end

    assign stage_valid = s1_valid_reg;
    assign stage       = s1_reg;

endmodule

// File: rtl/nps_best.sv
// Running best compare and update, plus the result register.
module nps_best (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stage_valid,
    input  nps_pkg::dist_stage_t stage,
    input  nps_pkg::limit_t      gravity_limit,
    output logic                 advance,
    output logic                 result_valid,
    input  logic                 result_ready,
    output nps_pkg::snap_out_t   result
);
    import nps_pkg::*;

    best_dist_t best_distance_reg;
    best_dist_t best_distance_next;
    logic       have_best_reg;
    logic       have_best_next;
    coord_t     best_x_reg;
    coord_t     best_y_reg;
    index_t     best_element_reg;
    index_t     best_point_reg;
    logic       result_valid_reg;
    logic       result_valid_next;
    snap_out_t  result_reg;
    snap_out_t  result_next;

    dist_sum_t  dist_sum;
    dist_t      point_dist;
    logic       take;
    logic       update;
    logic       finish;

    // Hold only a finishing item while the result register is still full.
    assign advance = !(stage_valid && stage.last_item && result_valid_reg && !result_ready);
    assign take    = stage_valid && advance;

    always_comb
    begin
        dist_sum   = {1'b0, stage.sq_x} + {1'b0, stage.sq_y};
        point_dist = dist_t'(dist_sum);
        update     = take && stage.has_point
                   && (point_dist < dist_t'(best_distance_reg))
                   && (point_dist < dist_t'(gravity_limit));
        finish     = take && stage.last_item;

        best_distance_next = best_distance_reg;
        have_best_next     = have_best_reg;
        if (update)
        begin
            best_distance_next = best_dist_t'(point_dist);
            have_best_next     = 1'b1;
        end
        if (finish)
        begin
            best_distance_next = START_DISTANCE;
            have_best_next     = 1'b0;
        end

        result_next = '0;
        if (update)
        begin
            result_next.snap_x        = stage.point_x;
            result_next.snap_y        = stage.point_y;
            result_next.found         = 1'b1;
            result_next.found_element = stage.element_index;
            result_next.found_point   = stage.point_index;
        end
        else if (have_best_reg)
        begin
            result_next.snap_x        = best_x_reg;
            result_next.snap_y        = best_y_reg;
            result_next.found         = 1'b1;
            result_next.found_element = best_element_reg;
            result_next.found_point   = best_point_reg;
        end
        else
        begin
            result_next.snap_x = stage.query_x;
            result_next.snap_y = stage.query_y;
        end

        if (finish)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && !result_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_distance_reg <= START_DISTANCE;
            have_best_reg     <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            best_distance_reg <= best_distance_next;
            have_best_reg     <= have_best_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            best_x_reg       <= stage.point_x;
            best_y_reg       <= stage.point_y;
            best_element_reg <= stage.element_index;
            best_point_reg   <= stage.point_index;
        end
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> result_valid_reg)
        else $error("finishing item did not load the result register");

    a_finish_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (!have_best_reg && best_distance_reg == START_DISTANCE))
        else $error("search state not rearmed after a finishing item");

    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        best_distance_reg <= START_DISTANCE)
        else $error("running best above the start distance");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.found)
        |-> (result_reg.found_element == '0 && result_reg.found_point == '0))
        else $error("indices set on a result with nothing found");
`endif

endmodule

// File: rtl/nearest_point_snap_core.sv
// Top level of the nearest point snap search.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------
//   item     | item_valid / item_ready  | item   (nps_pkg::snap_in_t)
//   result   | result_valid/result_ready| result (nps_pkg::snap_out_t)
//   cfg      | cfg_valid / cfg_ready    | cfg_data (gravity limit, 33 b)
//
// One item is taken per cycle while item_ready is high; a finishing item passes
// through the input register, the square register and the result register,
// after which its result is valid and can be taken.
// The only loop-carried path is the distance compare and best update in nps_best.
// Reset clears the pipeline valids, rearms the running best at 10000 and loads
// the gravity limit with 10000.
// item_ready drops only when a finishing item waits behind a result that the
// downstream side has not taken; other items keep flowing past a held result.
// cfg_ready is always high; write the limit only while the block is idle.
module nearest_point_snap_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  nps_pkg::snap_in_t            item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output nps_pkg::snap_out_t           result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [nps_pkg::LIMIT_BITS-1:0] cfg_data
);
    import nps_pkg::*;

    limit_t      gravity_limit_reg;
    logic        advance;
    logic        stage_valid;
    dist_stage_t stage;

    // Gravity limit register: take every cfg transaction.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            gravity_limit_reg <= cfg_data;
        end
    end

    // Input register and squared differences.
    nps_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    // Distance sum, compare against best and limit, result register.
    nps_best u_best (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage_valid   (stage_valid),
        .stage         (stage),
        .gravity_limit (gravity_limit_reg),
        .advance       (advance),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

endmodule
